// File: rtl/priority_landing_takeoff_scheduler_defines.svh
// ----------------------------------------------------------------------------
// Scheduler assertion macros
// Concurrent assertion helpers, compiled out when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef PRIORITY_LANDING_TAKEOFF_SCHEDULER_DEFINES_SVH
`define PRIORITY_LANDING_TAKEOFF_SCHEDULER_DEFINES_SVH

`ifndef SYNTH
// property must always hold outside reset
`define PLTS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("plts assertion failed");
// antecedent implies consequent on the next edge
`define PLTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("plts assertion failed");
`else
`define PLTS_ASSERT(lbl, clk, rst_n, prop)
`define PLTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

// File: rtl/plts_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Widths, depths, codes and entry types shared by the scheduler files.
// ----------------------------------------------------------------------------
package plts_pkg;

  localparam int URG_DEPTH = 16;
  localparam int NRM_DEPTH = 16;

  localparam int URG_IDX_W = $clog2(URG_DEPTH);
  localparam int URG_CNT_W = $clog2(URG_DEPTH + 1);
  localparam int NRM_IDX_W = $clog2(NRM_DEPTH);
  localparam int NRM_CNT_W = $clog2(NRM_DEPTH + 1);

  localparam int OP_W     = 2;
  localparam int TAG_W    = 40;
  localparam int SEV_W    = 8;
  localparam int STAMP_W  = 32;
  localparam int STATUS_W = 3;

  typedef logic [URG_IDX_W-1:0] uidx_t;
  typedef logic [URG_CNT_W-1:0] ucnt_t;
  typedef logic [NRM_IDX_W-1:0] nidx_t;
  typedef logic [NRM_CNT_W-1:0] ncnt_t;

  typedef enum logic [OP_W-1:0] {
    OP_NORMAL = 2'd0,
    OP_URGENT = 2'd1,
    OP_SERVE  = 2'd2
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STS_URGENT  = 3'd0,
    STS_NORMAL  = 3'd1,
    STS_NONE    = 3'd2,
    STS_STORED  = 3'd3,
    STS_DROPPED = 3'd4
  } status_e;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SEV_W-1:0]   sev;
    logic [STAMP_W-1:0] stamp;
  } urg_entry_t;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } nrm_entry_t;

endpackage

// File: rtl/plts_if.sv
// ----------------------------------------------------------------------------
// Scheduler channels
// Valid/ready request and response interfaces.
// ----------------------------------------------------------------------------
interface plts_req_if;
  logic                          valid;
  logic                          ready;
  logic [plts_pkg::OP_W-1:0]     opcode;
  logic [plts_pkg::TAG_W-1:0]    flight_tag;
  logic [plts_pkg::SEV_W-1:0]    severity;

  modport source (output valid, output opcode, output flight_tag, output severity,
                  input ready);
  modport sink   (input valid, input opcode, input flight_tag, input severity,
                  output ready);
endinterface

interface plts_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [plts_pkg::STATUS_W-1:0] status;
  logic [plts_pkg::TAG_W-1:0]    served_tag;
  logic [plts_pkg::SEV_W-1:0]    served_severity;
  logic [plts_pkg::STAMP_W-1:0]  served_stamp;

  modport source (output valid, output status, output served_tag,
                  output served_severity, output served_stamp, input ready);
  modport sink   (input valid, input status, input served_tag,
                  input served_severity, input served_stamp, output ready);
endinterface

// File: rtl/plts_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module plts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: rtl/priority_landing_takeoff_scheduler.sv
// ----------------------------------------------------------------------------
// Priority landing/takeoff scheduler
// Urgent requests go to an arrival-ordered store, normal ones onto a stack;
// a serve request takes the worst urgent entry, else the newest normal one.
// ----------------------------------------------------------------------------
//  channel | dir | fields
//  --------+-----+---------------------------------------------------------
//  req_i   | in  | opcode, flight_tag, severity
//  rsp_o   | out | status, served_tag, served_severity, served_stamp
//
//  Stores and stack requests pass through ST_DONE; a normal serve through
//  ST_NPOP, then ST_DONE. An urgent serve scans all stored entries, then
//  closes up those above the best; one urgent RAM port pair does the scan,
//  then the close-up. req_i.ready is high only while the sequencer is idle.
//  A finished response waits in the output register, and the next request
//  is still taken. Reset clears counts and the stamp clock; no clearing pass.
`include "priority_landing_takeoff_scheduler_defines.svh"

module priority_landing_takeoff_scheduler (
  input  logic        clk_i,
  input  logic        rst_ni,
  plts_req_if.sink    req_i,
  plts_rsp_if.source  rsp_o
);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SCAN  = 5'b00010,
    ST_SHIFT = 5'b00100,
    ST_NPOP  = 5'b01000,
    ST_DONE  = 5'b10000
  } state_e;

  state_e                        state_q, state_d;
  plts_pkg::ucnt_t               ucnt_q, ucnt_d;
  plts_pkg::ncnt_t               ncnt_q, ncnt_d;
  logic [plts_pkg::STAMP_W-1:0]  rclk_q, rclk_d;
  plts_pkg::ucnt_t               rd_ptr_q, rd_ptr_d;
  plts_pkg::uidx_t               cmp_ptr_q, cmp_ptr_d;
  plts_pkg::uidx_t               best_ptr_q, best_ptr_d;
  logic                          wr_pend_q, wr_pend_d;
  logic                          rsp_valid_q, rsp_valid_d;

  plts_pkg::status_e             res_status_q, res_status_d;
  logic [plts_pkg::TAG_W-1:0]    res_tag_q, res_tag_d;
  logic [plts_pkg::SEV_W-1:0]    res_sev_q, res_sev_d;
  logic [plts_pkg::STAMP_W-1:0]  res_stamp_q, res_stamp_d;

  plts_pkg::status_e             out_status_q, out_status_d;
  logic [plts_pkg::TAG_W-1:0]    out_tag_q, out_tag_d;
  logic [plts_pkg::SEV_W-1:0]    out_sev_q, out_sev_d;
  logic [plts_pkg::STAMP_W-1:0]  out_stamp_q, out_stamp_d;

  logic                          u_we;
  plts_pkg::uidx_t               u_waddr, u_raddr;
  plts_pkg::urg_entry_t          u_wdata, u_rdata;
  logic                          n_we;
  plts_pkg::nidx_t               n_waddr, n_raddr;
  plts_pkg::nrm_entry_t          n_wdata, n_rdata;

  logic                          best_upd;
  plts_pkg::uidx_t               best_nxt;

  plts_ram #(
    .WIDTH ($bits(plts_pkg::urg_entry_t)),
    .DEPTH (plts_pkg::URG_DEPTH)
  ) u_urg_ram (
    .clk_i   (clk_i),
    .we_i    (u_we),
    .waddr_i (u_waddr),
    .wdata_i (u_wdata),
    .raddr_i (u_raddr),
    .rdata_o (u_rdata)
  );

  plts_ram #(
    .WIDTH ($bits(plts_pkg::nrm_entry_t)),
    .DEPTH (plts_pkg::NRM_DEPTH)
  ) u_nrm_ram (
    .clk_i   (clk_i),
    .we_i    (n_we),
    .waddr_i (n_waddr),
    .wdata_i (n_wdata),
    .raddr_i (n_raddr),
    .rdata_o (n_rdata)
  );

  assign req_i.ready = (state_q == ST_IDLE);

  assign rsp_o.valid           = rsp_valid_q;
  assign rsp_o.status          = out_status_q;
  assign rsp_o.served_tag      = out_tag_q;
  assign rsp_o.served_severity = out_sev_q;
  assign rsp_o.served_stamp    = out_stamp_q;

  // strictly greater keeps the lowest position on a tie
  assign best_upd = (cmp_ptr_q == '0) || (u_rdata.sev > res_sev_q);
  assign best_nxt = best_upd ? cmp_ptr_q : best_ptr_q;

  always_comb begin
    state_d      = state_q;
    ucnt_d       = ucnt_q;
    ncnt_d       = ncnt_q;
    rclk_d       = rclk_q;
    rd_ptr_d     = rd_ptr_q;
    cmp_ptr_d    = cmp_ptr_q;
    best_ptr_d   = best_ptr_q;
    wr_pend_d    = wr_pend_q;
    rsp_valid_d  = rsp_valid_q && !rsp_o.ready;
    res_status_d = res_status_q;
    res_tag_d    = res_tag_q;
    res_sev_d    = res_sev_q;
    res_stamp_d  = res_stamp_q;
    out_status_d = out_status_q;
    out_tag_d    = out_tag_q;
    out_sev_d    = out_sev_q;
    out_stamp_d  = out_stamp_q;

    u_we          = 1'b0;
    u_waddr       = ucnt_q[plts_pkg::URG_IDX_W-1:0];
    u_wdata.tag   = req_i.flight_tag;
    u_wdata.sev   = req_i.severity;
    u_wdata.stamp = rclk_q;
    u_raddr       = '0;
    n_we          = 1'b0;
    n_waddr       = ncnt_q[plts_pkg::NRM_IDX_W-1:0];
    n_wdata.tag   = req_i.flight_tag;
    n_wdata.stamp = rclk_q;
    n_raddr       = plts_pkg::nidx_t'(ncnt_q - 1'b1);

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          res_tag_d   = '0;
          res_sev_d   = '0;
          res_stamp_d = '0;
          state_d     = ST_DONE;
          case (req_i.opcode)
            plts_pkg::OP_NORMAL: begin
              rclk_d = rclk_q + 1'b1;
              if (ncnt_q >= plts_pkg::ncnt_t'(plts_pkg::NRM_DEPTH)) begin
                res_status_d = plts_pkg::STS_DROPPED;
              end else begin
                n_we         = 1'b1;
                ncnt_d       = ncnt_q + 1'b1;
                res_status_d = plts_pkg::STS_STORED;
              end
            end
            plts_pkg::OP_URGENT: begin
              rclk_d = rclk_q + 1'b1;
              if (ucnt_q >= plts_pkg::ucnt_t'(plts_pkg::URG_DEPTH)) begin
                res_status_d = plts_pkg::STS_DROPPED;
              end else begin
                u_we         = 1'b1;
                ucnt_d       = ucnt_q + 1'b1;
                res_status_d = plts_pkg::STS_STORED;
              end
            end
            plts_pkg::OP_SERVE: begin
              if (ucnt_q != '0) begin
                u_raddr      = '0;
                cmp_ptr_d    = '0;
                best_ptr_d   = '0;
                rd_ptr_d     = plts_pkg::ucnt_t'(1);
                res_status_d = plts_pkg::STS_URGENT;
                state_d      = ST_SCAN;
              end else if (ncnt_q != '0) begin
                ncnt_d       = ncnt_q - 1'b1;
                res_status_d = plts_pkg::STS_NORMAL;
                state_d      = ST_NPOP;
              end else begin
                res_status_d = plts_pkg::STS_NONE;
              end
            end
            default: begin
              res_status_d = plts_pkg::STS_NONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (best_upd) begin
          best_ptr_d  = cmp_ptr_q;
          res_tag_d   = u_rdata.tag;
          res_sev_d   = u_rdata.sev;
          res_stamp_d = u_rdata.stamp;
        end
        if (rd_ptr_q < ucnt_q) begin
          u_raddr   = rd_ptr_q[plts_pkg::URG_IDX_W-1:0];
          cmp_ptr_d = rd_ptr_q[plts_pkg::URG_IDX_W-1:0];
          rd_ptr_d  = rd_ptr_q + 1'b1;
        end else begin
          // last entry compared: close up from the one above the winner
          rd_ptr_d  = plts_pkg::ucnt_t'(best_nxt) + 1'b1;
          wr_pend_d = 1'b0;
          state_d   = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (wr_pend_q) begin
          u_we    = 1'b1;
          u_waddr = cmp_ptr_q;
          u_wdata = u_rdata;
        end
        if (rd_ptr_q < ucnt_q) begin
          u_raddr   = rd_ptr_q[plts_pkg::URG_IDX_W-1:0];
          cmp_ptr_d = plts_pkg::uidx_t'(rd_ptr_q - 1'b1);
          rd_ptr_d  = rd_ptr_q + 1'b1;
          wr_pend_d = 1'b1;
        end else begin
          wr_pend_d = 1'b0;
          if (!wr_pend_q) begin
            ucnt_d  = ucnt_q - 1'b1;
            state_d = ST_DONE;
          end
        end
      end
      ST_NPOP: begin
        res_tag_d   = n_rdata.tag;
        res_stamp_d = n_rdata.stamp;
        state_d     = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_tag_d    = res_tag_q;
          out_sev_d    = res_sev_q;
          out_stamp_d  = res_stamp_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ucnt_q      <= '0;
      ncnt_q      <= '0;
      rclk_q      <= '0;
      rd_ptr_q    <= '0;
      wr_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ucnt_q      <= ucnt_d;
      ncnt_q      <= ncnt_d;
      rclk_q      <= rclk_d;
      rd_ptr_q    <= rd_ptr_d;
      wr_pend_q   <= wr_pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_ptr_q    <= cmp_ptr_d;
    best_ptr_q   <= best_ptr_d;
    res_status_q <= res_status_d;
    res_tag_q    <= res_tag_d;
    res_sev_q    <= res_sev_d;
    res_stamp_q  <= res_stamp_d;
    out_status_q <= out_status_d;
    out_tag_q    <= out_tag_d;
    out_sev_q    <= out_sev_d;
    out_stamp_q  <= out_stamp_d;
  end

  `PLTS_ASSERT(a_cnt_bound, clk_i, rst_ni, (ucnt_q <= plts_pkg::ucnt_t'(plts_pkg::URG_DEPTH)) && (ncnt_q <= plts_pkg::ncnt_t'(plts_pkg::NRM_DEPTH)))
  `PLTS_ASSERT(a_scan_nonempty, clk_i, rst_ni, (state_q != ST_SCAN) || (ucnt_q != '0))
  `PLTS_ASSERT_NEXT(a_urg_served_pops, clk_i, rst_ni, (state_q == ST_SHIFT) && (state_d == ST_DONE), ($past(ucnt_q) == ucnt_q + 1'b1) && (res_status_q == plts_pkg::STS_URGENT))

endmodule
